// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the sequencer register file RTL.
// Each macro expects i_clk and i_rst_n in the scope of the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds on every clock edge out of reset
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Check that a condition on one edge implies another on the following edge
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/vsr_pkg.sv =====
// Types and constants of the VGA sequencer register file.
// Used by vsr_cfg, vsr_core and the top level; depends on nothing.
package vsr_pkg;

    // Access kinds carried by an input item
    typedef enum logic [1:0] {
        MODE_WR_INDEX = 2'd0,
        MODE_RD_INDEX = 2'd1,
        MODE_WR_DATA  = 2'd2,
        MODE_RD_DATA  = 2'd3
    } t_mode;

    // Chipset kinds
    localparam logic [2:0] KIND_VGA     = 3'd0;
    localparam logic [2:0] KIND_TRIO    = 3'd1;
    localparam logic [2:0] KIND_ET_4K   = 3'd2;
    localparam logic [2:0] KIND_ET_3K   = 3'd3;
    localparam logic [2:0] KIND_EGA     = 3'd4;

    // Index masks per chipset kind
    localparam logic [7:0] IDX_MASK_WIDE   = 8'h3F;
    localparam logic [7:0] IDX_MASK_NARROW = 8'h07;
    localparam logic [7:0] IDX_MASK_STD    = 8'h0F;

    // Sequencer data register indexes
    localparam logic [7:0] SEQ_RESET     = 8'd0;
    localparam logic [7:0] SEQ_CLOCKING  = 8'd1;
    localparam logic [7:0] SEQ_MAP_MASK  = 8'd2;
    localparam logic [7:0] SEQ_CHAR_MAP  = 8'd3;
    localparam logic [7:0] SEQ_MEM_MODE  = 8'd4;

    // Clocking mode bits
    localparam logic [7:0] CLK_NO_BLANK_MASK = 8'hDF;
    localparam int         CLK_SCREEN_OFF    = 5;

    // Memory mode bits
    localparam int MEM_EXT_MEM  = 1;
    localparam int MEM_ODDEVEN  = 2;
    localparam int MEM_CHAIN4   = 3;

    localparam logic [3:0] MAP_ALL_PLANES = 4'hF;

    // Configuration register indexes
    localparam logic [1:0] CFG_CHIPSET_KIND    = 2'd0;
    localparam logic [1:0] CFG_IGNORE_BLANKING = 2'd1;
    localparam logic [1:0] CFG_IGNORE_OE_256   = 2'd2;
    localparam logic [1:0] CFG_IGNORE_EXT_MEM  = 2'd3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 56;

    // Configuration seen by the core
    typedef struct packed {
        logic [2:0] chipset_kind;
        logic       ignore_blanking;
        logic       ignore_oddeven_256;
        logic       ignore_ext_mem;
    } t_cfg;

    // One input item
    typedef struct packed {
        t_mode      mode;
        logic [7:0] value;
        logic       is_256color_mode;
        logic       gfx_oddeven;
    } t_item;

    // One result item
    typedef struct packed {
        logic [7:0]  read_data;
        logic        screen_blank;
        logic        resize_request;
        logic [31:0] plane_write_mask;
        logic [2:0]  font_map_a;
        logic [2:0]  font_map_b;
        logic        chained;
        logic        flag_map_mask;
        logic        flag_oddeven;
        logic        flag_small_memory;
        logic        unhandled_index;
    } t_result;

endpackage

// ===== rtl/vga_sequencer_register_file.sv =====
// Top level of the VGA sequencer register file: input and result registers.
// Depends on vsr_pkg, vsr_cfg, vsr_core and assert_macros.svh.
//
//  channel   | direction | valid / ready                     | payload
//  s_axis    | in        | i_s_axis_tvalid / o_s_axis_tready | i_s_axis_tdata [15:0]
//  m_axis    | out       | o_m_axis_tvalid / i_m_axis_tready | o_m_axis_tdata [55:0]
//  cfg       | in        | i_cfg_valid / o_cfg_ready         | i_cfg_index, i_cfg_data
//
// One item per cycle unless the result side stalls: an item waits in the input register, then the
// register update and the result are computed combinationally and registered in the result register.
// Reset is synchronous and returns the valid flags, the sequencer state and the configuration values to their defaults.
// A stalled result holds both registers; the input side keeps accepting while a stage is free.
// The configuration port is always ready.
`include "assert_macros.svh"

module vga_sequencer_register_file (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [1:0] mode, [9:2] value, [10] is_256color_mode, [11] gfx_oddeven, [15:12] zero
    input  logic [vsr_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [7:0] read_data, [8] screen_blank, [9] resize_request, [41:10] plane_write_mask,
    // [44:42] font_map_a, [47:45] font_map_b, [48] chained, [49] flag_map_mask,
    // [50] flag_oddeven, [51] flag_small_memory, [52] unhandled_index, [55:53] zero
    output logic [vsr_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [vsr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [vsr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import vsr_pkg::*;

    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out;
    t_result w_result;
    t_cfg    w_cfg;
    logic    w_adv;
    logic    w_step;
    logic    w_in_take;

    // Advance when the result register is free or being emptied
    assign w_adv           = !r_out_valid || i_m_axis_tready;
    assign w_step          = r_in_valid && w_adv;
    assign o_s_axis_tready = !r_in_valid || w_adv;
    assign w_in_take       = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    vsr_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    vsr_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_step   (w_step),
        .i_item   (r_in_item),
        .o_result (w_result)
    );

    // Input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    // Input register payload
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_item.mode             <= t_mode'(i_s_axis_tdata[1:0]);
            r_in_item.value            <= i_s_axis_tdata[9:2];
            r_in_item.is_256color_mode <= i_s_axis_tdata[10];
            r_in_item.gfx_oddeven      <= i_s_axis_tdata[11];
        end
    end

    // Result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'd0,
                              r_out.unhandled_index,
                              r_out.flag_small_memory,
                              r_out.flag_oddeven,
                              r_out.flag_map_mask,
                              r_out.chained,
                              r_out.font_map_b,
                              r_out.font_map_a,
                              r_out.plane_write_mask,
                              r_out.resize_request,
                              r_out.screen_blank,
                              r_out.read_data};

    // A held item stays in the input register unchanged until it moves on
    `ASSERT_NEXT(a_in_hold, r_in_valid && !w_adv, r_in_valid && $stable(r_in_item), "input item lost while stalled")

endmodule

// ===== rtl/vsr_cfg.sv =====
// Configuration registers of the sequencer register file.
// Depends on vsr_pkg.
module vsr_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [vsr_pkg::CFG_IDX_W-1:0]  i_wr_index,
    input  logic [vsr_pkg::CFG_DATA_W-1:0] i_wr_data,
    output vsr_pkg::t_cfg                  o_cfg
);
    import vsr_pkg::*;

    t_cfg r_cfg;

    // Write one register per accepted write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.chipset_kind       <= KIND_VGA;
            r_cfg.ignore_blanking    <= 1'b0;
            r_cfg.ignore_oddeven_256 <= 1'b1;
            r_cfg.ignore_ext_mem     <= 1'b0;
        end else if (i_wr_en) begin
            case (i_wr_index)
                CFG_CHIPSET_KIND:    r_cfg.chipset_kind       <= i_wr_data;
                CFG_IGNORE_BLANKING: r_cfg.ignore_blanking    <= i_wr_data[0];
                CFG_IGNORE_OE_256:   r_cfg.ignore_oddeven_256 <= i_wr_data[0];
                CFG_IGNORE_EXT_MEM:  r_cfg.ignore_ext_mem     <= i_wr_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/vsr_core.sv =====
// Sequencer register state and the derived display flags.
// Depends on vsr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module vsr_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  vsr_pkg::t_cfg    i_cfg,
    input  logic             i_step,
    input  vsr_pkg::t_item   i_item,
    output vsr_pkg::t_result o_result
);
    import vsr_pkg::*;

    logic [7:0] r_index,    n_index;
    logic [7:0] r_reset,    n_reset;
    logic [7:0] r_clocking, n_clocking;
    logic [3:0] r_map_mask, n_map_mask;
    logic [7:0] r_char_map, n_char_map;
    logic [7:0] r_mem_mode, n_mem_mode;
    logic       r_blank,    n_blank;
    logic       r_chain,    n_chain;
    logic       r_fl_map,   n_fl_map;
    logic       r_fl_oe,    n_fl_oe;
    logic       r_fl_small, n_fl_small;

    logic       w_is_vga;
    logic [7:0] w_idx_mask;
    logic [7:0] w_rd;
    logic       w_resize;
    logic       w_unhandled;

    assign w_is_vga = (i_cfg.chipset_kind != KIND_EGA);

    // Pick the index mask for the chipset kind
    always_comb begin
        case (i_cfg.chipset_kind)
            KIND_TRIO:  w_idx_mask = IDX_MASK_WIDE;
            KIND_ET_4K: w_idx_mask = IDX_MASK_NARROW;
            KIND_ET_3K: w_idx_mask = IDX_MASK_NARROW;
            default:    w_idx_mask = IDX_MASK_STD;
        endcase
    end

    // Decode one access and work out the next register state
    always_comb begin
        n_index     = r_index;
        n_reset     = r_reset;
        n_clocking  = r_clocking;
        n_map_mask  = r_map_mask;
        n_char_map  = r_char_map;
        n_mem_mode  = r_mem_mode;
        n_blank     = r_blank;
        n_chain     = r_chain;
        n_fl_map    = r_fl_map;
        n_fl_oe     = r_fl_oe;
        n_fl_small  = r_fl_small;
        w_rd        = 8'd0;
        w_resize    = 1'b0;
        w_unhandled = 1'b0;
        case (i_item.mode)
            MODE_WR_INDEX: n_index = i_item.value & w_idx_mask;
            MODE_RD_INDEX: w_rd = r_index;
            MODE_WR_DATA: begin
                case (r_index)
                    SEQ_RESET: n_reset = i_item.value;
                    SEQ_CLOCKING: begin
                        // a rewrite of the same value changes nothing
                        if (i_item.value != r_clocking) begin
                            w_resize   = (i_item.value & CLK_NO_BLANK_MASK)
                                         != (r_clocking & CLK_NO_BLANK_MASK);
                            n_clocking = i_item.value;
                            n_blank    = i_item.value[CLK_SCREEN_OFF]
                                         & ~i_cfg.ignore_blanking;
                        end
                    end
                    SEQ_MAP_MASK: begin
                        n_map_mask = i_item.value[3:0];
                        n_fl_map   = (i_item.value[3:0] != MAP_ALL_PLANES) & r_chain;
                    end
                    SEQ_CHAR_MAP: n_char_map = i_item.value;
                    SEQ_MEM_MODE: begin
                        n_mem_mode = i_item.value;
                        n_fl_small = ~i_item.value[MEM_EXT_MEM] & ~i_cfg.ignore_ext_mem;
                        if (i_cfg.ignore_oddeven_256 && i_item.is_256color_mode) begin
                            n_fl_oe = 1'b0;
                        end else begin
                            n_fl_oe = ~i_item.value[MEM_ODDEVEN] | i_item.gfx_oddeven;
                        end
                        // EGA keeps chain-4 and the map mask flag
                        if (w_is_vga) begin
                            n_chain  = i_item.value[MEM_CHAIN4];
                            n_fl_map = (r_map_mask != MAP_ALL_PLANES)
                                       & i_item.value[MEM_CHAIN4];
                        end
                    end
                    default: w_unhandled = 1'b1;
                endcase
            end
            MODE_RD_DATA: begin
                case (r_index)
                    SEQ_RESET:    w_rd = r_reset;
                    SEQ_CLOCKING: w_rd = r_clocking;
                    SEQ_MAP_MASK: w_rd = {4'd0, r_map_mask};
                    SEQ_CHAR_MAP: w_rd = r_char_map;
                    SEQ_MEM_MODE: w_rd = r_mem_mode;
                    default:      w_unhandled = 1'b1;
                endcase
            end
            default: ;
        endcase
    end

    // Build the result from the updated state
    always_comb begin
        o_result.read_data         = w_rd;
        o_result.screen_blank      = n_blank;
        o_result.resize_request    = w_resize;
        o_result.plane_write_mask  = {{8{n_map_mask[3]}}, {8{n_map_mask[2]}},
                                      {8{n_map_mask[1]}}, {8{n_map_mask[0]}}};
        o_result.font_map_a        = {n_char_map[1:0], w_is_vga & n_char_map[4]};
        o_result.font_map_b        = {n_char_map[3:2], w_is_vga & n_char_map[5]};
        o_result.chained           = n_chain;
        o_result.flag_map_mask     = n_fl_map;
        o_result.flag_oddeven      = n_fl_oe;
        o_result.flag_small_memory = n_fl_small;
        o_result.unhandled_index   = w_unhandled;
    end

    // Commit the state when the item moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index    <= 8'd0;
            r_reset    <= 8'd0;
            r_clocking <= 8'd0;
            r_map_mask <= 4'd0;
            r_char_map <= 8'd0;
            r_mem_mode <= 8'd0;
            r_blank    <= 1'b0;
            r_chain    <= 1'b0;
            r_fl_map   <= 1'b0;
            r_fl_oe    <= 1'b0;
            r_fl_small <= 1'b0;
        end else if (i_step) begin
            r_index    <= n_index;
            r_reset    <= n_reset;
            r_clocking <= n_clocking;
            r_map_mask <= n_map_mask;
            r_char_map <= n_char_map;
            r_mem_mode <= n_mem_mode;
            r_blank    <= n_blank;
            r_chain    <= n_chain;
            r_fl_map   <= n_fl_map;
            r_fl_oe    <= n_fl_oe;
            r_fl_small <= n_fl_small;
        end
    end

    // The map mask flag is only ever raised while chain-4 is on
    `ASSERT_ALWAYS(a_map_flag_needs_chain, !r_fl_map || r_chain, "map mask flag without chain-4")
    // No chipset keeps more than six index bits
    `ASSERT_ALWAYS(a_index_width, r_index[7:6] == 2'b00, "index register above six bits")

endmodule

// ===== tb/vga_sequencer_register_file_tb.sv =====
// Testbench for the VGA sequencer register file: directed and random port accesses.
// Predicts every result from its own register model and checks it field by field.
// Depends on vsr_pkg and the vga_sequencer_register_file RTL only.
`timescale 1ns / 100ps

module vga_sequencer_register_file_tb;
    import vsr_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_ACCESSES = 160;
    localparam int BURST_ACCESSES = 150;

    // Chipset kinds beyond the defined ones behave as the generic VGA
    localparam logic [2:0] KIND_SPARE_5 = 3'd5;
    localparam logic [2:0] KIND_SPARE_6 = 3'd6;
    localparam logic [2:0] KIND_SPARE_7 = 3'd7;

    localparam logic [7:0] SCREEN_OFF_BIT = 8'h01 << CLK_SCREEN_OFF;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    vga_sequencer_register_file dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // Register model of the sequencer
    t_cfg       model_cfg;
    logic [7:0] seq_index;
    logic [7:0] seq_reset;
    logic [7:0] seq_clocking;
    logic [3:0] seq_map_mask;
    logic [7:0] seq_char_map;
    logic [7:0] seq_mem_mode;
    logic       blank_on;
    logic       chain4_on;
    logic       slow_map_mask;
    logic       slow_oddeven;
    logic       slow_small_mem;

    t_result    expected_results[$];
    int         mismatch_count = 0;
    int         accesses_sent = 0;
    int         cycle_count = 0;
    bit         sender_quiet = 0;
    bit         receiver_quiet = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_results.size());
            $display("** vga_sequencer_register_file: FAILED **");
            $finish;
        end
    end

    function automatic logic map_mask_slow();
        return (seq_map_mask != MAP_ALL_PLANES) && chain4_on;
    endfunction

    // Apply one port access to the model and return the result it produces
    function automatic t_result sequencer_access(logic [IN_DATA_W-1:0] word);
        t_mode      access;
        logic [7:0] v;
        logic       in_256;
        logic       goe;
        logic       vga;
        t_result    r;
        access = t_mode'(word[1:0]);
        v      = word[9:2];
        in_256 = word[10];
        goe    = word[11];
        vga    = (model_cfg.chipset_kind != KIND_EGA);
        r      = '0;
        case (access)
            MODE_WR_INDEX: begin
                case (model_cfg.chipset_kind)
                    KIND_TRIO:              seq_index = v & IDX_MASK_WIDE;
                    KIND_ET_4K, KIND_ET_3K: seq_index = v & IDX_MASK_NARROW;
                    default:                seq_index = v & IDX_MASK_STD;
                endcase
            end
            MODE_RD_INDEX: r.read_data = seq_index;
            MODE_WR_DATA: begin
                case (seq_index)
                    SEQ_RESET: seq_reset = v;
                    SEQ_CLOCKING: begin
                        // A rewrite of the same value changes nothing
                        if (v != seq_clocking) begin
                            if ((v & CLK_NO_BLANK_MASK) != (seq_clocking & CLK_NO_BLANK_MASK))
                                r.resize_request = 1'b1;
                            seq_clocking = v;
                            blank_on = v[CLK_SCREEN_OFF] && !model_cfg.ignore_blanking;
                        end
                    end
                    SEQ_MAP_MASK: begin
                        seq_map_mask  = v[3:0];
                        slow_map_mask = map_mask_slow();
                    end
                    SEQ_CHAR_MAP: seq_char_map = v;
                    SEQ_MEM_MODE: begin
                        seq_mem_mode   = v;
                        slow_small_mem = !v[MEM_EXT_MEM] && !model_cfg.ignore_ext_mem;
                        if (model_cfg.ignore_oddeven_256 && in_256)
                            slow_oddeven = 1'b0;
                        else
                            slow_oddeven = !v[MEM_ODDEVEN] || goe;
                        // EGA keeps its chain and map mask flags
                        if (vga) begin
                            chain4_on     = v[MEM_CHAIN4];
                            slow_map_mask = map_mask_slow();
                        end
                    end
                    default: r.unhandled_index = 1'b1;
                endcase
            end
            default: begin
                case (seq_index)
                    SEQ_RESET:    r.read_data = seq_reset;
                    SEQ_CLOCKING: r.read_data = seq_clocking;
                    SEQ_MAP_MASK: r.read_data = {4'h0, seq_map_mask};
                    SEQ_CHAR_MAP: r.read_data = seq_char_map;
                    SEQ_MEM_MODE: r.read_data = seq_mem_mode;
                    default:      r.unhandled_index = 1'b1;
                endcase
            end
        endcase
        // Derived state seen on every result
        r.screen_blank = blank_on;
        for (int i = 0; i < 4; i++)
            r.plane_write_mask[8*i +: 8] = {8{seq_map_mask[i]}};
        r.font_map_a        = {seq_char_map[1:0], vga & seq_char_map[4]};
        r.font_map_b        = {seq_char_map[3:2], vga & seq_char_map[5]};
        r.chained           = chain4_on;
        r.flag_map_mask     = slow_map_mask;
        r.flag_oddeven      = slow_oddeven;
        r.flag_small_memory = slow_small_mem;
        return r;
    endfunction

    function automatic t_result unpack_result(logic [OUT_DATA_W-1:0] d);
        t_result r;
        r.read_data         = d[7:0];
        r.screen_blank      = d[8];
        r.resize_request    = d[9];
        r.plane_write_mask  = d[41:10];
        r.font_map_a        = d[44:42];
        r.font_map_b        = d[47:45];
        r.chained           = d[48];
        r.flag_map_mask     = d[49];
        r.flag_oddeven      = d[50];
        r.flag_small_memory = d[51];
        r.unhandled_index   = d[52];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Track configuration writes, predict accepted items, check results
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_CHIPSET_KIND:    model_cfg.chipset_kind       = i_cfg_data;
                    CFG_IGNORE_BLANKING: model_cfg.ignore_blanking    = i_cfg_data[0];
                    CFG_IGNORE_OE_256:   model_cfg.ignore_oddeven_256 = i_cfg_data[0];
                    default:             model_cfg.ignore_ext_mem     = i_cfg_data[0];
                endcase
            end
            if (i_s_axis_tvalid && o_s_axis_tready)
                expected_results.push_back(sequencer_access(i_s_axis_tdata));
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = unpack_result(o_m_axis_tdata);
                if (expected_results.size() == 0) begin
                    $display("%0t: result with no access pending, expected none actual 0x%h",
                             $time, o_m_axis_tdata);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("read_data", 32'(want.read_data), 32'(got.read_data));
                    check_field("screen_blank", 32'(want.screen_blank),
                                32'(got.screen_blank));
                    check_field("resize_request", 32'(want.resize_request),
                                32'(got.resize_request));
                    check_field("plane_write_mask", want.plane_write_mask,
                                got.plane_write_mask);
                    check_field("font_map_a", 32'(want.font_map_a), 32'(got.font_map_a));
                    check_field("font_map_b", 32'(want.font_map_b), 32'(got.font_map_b));
                    check_field("chained", 32'(want.chained), 32'(got.chained));
                    check_field("flag_map_mask", 32'(want.flag_map_mask),
                                32'(got.flag_map_mask));
                    check_field("flag_oddeven", 32'(want.flag_oddeven),
                                32'(got.flag_oddeven));
                    check_field("flag_small_memory", 32'(want.flag_small_memory),
                                32'(got.flag_small_memory));
                    check_field("unhandled_index", 32'(want.unhandled_index),
                                32'(got.unhandled_index));
                end
            end
        end
    end

    // Result side back-pressure: ready bursts, short stalls and a few long ones
    initial begin
        int r;
        i_m_axis_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            r = $urandom_range(0, 99);
            if (receiver_quiet || r < 60) begin
                i_m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b0;
                repeat (r < 95 ? $urandom_range(1, 3) : $urandom_range(10, 30))
                    @(posedge i_clk);
            end
        end
    end

    // Send one access item, after a random idle gap
    task automatic send_access(input t_mode access, input logic [7:0] v,
                               input logic in_256, input logic goe);
        int r;
        int gap;
        r = $urandom_range(0, 99);
        if (sender_quiet || r < 55)
            gap = 0;
        else if (r < 95)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 30);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {4'h0, goe, in_256, v, access};
        do @(posedge i_clk); while (!o_s_axis_tready);
        accesses_sent++;
    endtask

    // Hold the sender until every pending result has come back or the drain limit runs out
    task automatic wait_all_results();
        int waited;
        waited = 0;
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write one register, then idle the write channel
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly index-then-data sequences with random content, some stray accesses
    task automatic send_random_transaction();
        int         r;
        logic [7:0] idx;
        logic [7:0] v;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            idx = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 4))
                                             : 8'($urandom_range(0, 255));
            send_access(MODE_WR_INDEX, idx, 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)));
            repeat ($urandom_range(1, 3)) begin
                v = 8'($urandom_range(0, 255));
                // Steer some writes to repeated or screen-off-toggled clocking values and all-ones or all-zero data
                if ($urandom_range(0, 3) == 0) begin
                    if (idx == SEQ_CLOCKING)
                        v = seq_clocking ^ ($urandom_range(0, 1) ? SCREEN_OFF_BIT : 8'h00);
                    else
                        v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                end
                send_access($urandom_range(0, 2) != 0 ? MODE_WR_DATA : MODE_RD_DATA, v,
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end else if (r < 85) begin
            send_access(MODE_RD_INDEX, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)));
        end else begin
            send_access(t_mode'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    // Walk every register under the reset configuration
    task automatic test_directed_accesses();
        // Index beyond the handled range, masked to 4 bits
        send_access(MODE_WR_INDEX, 8'hFF, 1'b0, 1'b0);
        send_access(MODE_RD_INDEX, 8'h00, 1'b0, 1'b0);
        send_access(MODE_WR_DATA, 8'hAA, 1'b0, 1'b0);
        send_access(MODE_RD_DATA, 8'h00, 1'b0, 1'b0);
        send_access(MODE_WR_INDEX, SEQ_RESET, 1'b0, 1'b0);
        send_access(MODE_WR_DATA, 8'hFF, 1'b0, 1'b0);
        send_access(MODE_RD_DATA, 8'h00, 1'b1, 1'b1);
        // Screen-off only, the same value again, then every bit
        send_access(MODE_WR_INDEX, SEQ_CLOCKING, 1'b0, 1'b0);
        send_access(MODE_WR_DATA, SCREEN_OFF_BIT, 1'b0, 1'b0);
        send_access(MODE_WR_DATA, SCREEN_OFF_BIT, 1'b0, 1'b0);
        send_access(MODE_WR_DATA, 8'hFF, 1'b0, 1'b0);
        send_access(MODE_RD_DATA, 8'h00, 1'b0, 1'b0);
        // Chain-4 in a 256-colour mode, then odd/even requested by the graphics side
        send_access(MODE_WR_INDEX, SEQ_MEM_MODE, 1'b0, 1'b0);
        send_access(MODE_WR_DATA, 8'h08, 1'b1, 1'b0);
        send_access(MODE_WR_DATA, 8'h0E, 1'b0, 1'b1);
        // Partial plane mask while chained, then all planes
        send_access(MODE_WR_INDEX, SEQ_MAP_MASK, 1'b0, 1'b0);
        send_access(MODE_WR_DATA, 8'h07, 1'b0, 1'b0);
        send_access(MODE_WR_DATA, 8'hFF, 1'b0, 1'b0);
        send_access(MODE_RD_DATA, 8'h00, 1'b0, 1'b0);
        send_access(MODE_WR_INDEX, SEQ_CHAR_MAP, 1'b0, 1'b0);
        send_access(MODE_WR_DATA, 8'h3F, 1'b0, 1'b0);
        send_access(MODE_RD_DATA, 8'h00, 1'b0, 1'b0);
        send_access(MODE_WR_DATA, 8'h00, 1'b0, 1'b0);
    endtask

    // Random traffic under each chipset kind and mixed option settings
    task automatic test_config_phases();
        logic [2:0] phase_kind [10];
        int         start;
        bit         paused;
        phase_kind = '{KIND_VGA, KIND_EGA, KIND_TRIO, KIND_ET_4K, KIND_ET_3K,
                       KIND_SPARE_5, KIND_SPARE_6, KIND_SPARE_7, KIND_EGA, KIND_TRIO};
        for (int p = 0; p < 10; p++) begin
            wait_all_results();
            cfg_write(CFG_CHIPSET_KIND, phase_kind[p]);
            if (p == 1) begin
                cfg_write(CFG_IGNORE_BLANKING, 3'd1);
                cfg_write(CFG_IGNORE_OE_256, 3'd1);
                cfg_write(CFG_IGNORE_EXT_MEM, 3'd1);
            end else if (p == 2) begin
                cfg_write(CFG_IGNORE_BLANKING, 3'd0);
                cfg_write(CFG_IGNORE_OE_256, 3'd0);
                cfg_write(CFG_IGNORE_EXT_MEM, 3'd0);
            end else begin
                cfg_write(CFG_IGNORE_BLANKING, 3'($urandom_range(0, 1)));
                cfg_write(CFG_IGNORE_OE_256, 3'($urandom_range(0, 1)));
                cfg_write(CFG_IGNORE_EXT_MEM, 3'($urandom_range(0, 1)));
            end
            start  = accesses_sent;
            paused = 0;
            while (accesses_sent - start < PHASE_ACCESSES) begin
                if (!paused && accesses_sent - start >= PHASE_ACCESSES / 2) begin
                    wait_all_results();
                    paused = 1;
                end
                send_random_transaction();
            end
        end
    endtask

    // Full-rate traffic with neither side idling
    task automatic test_back_to_back();
        int start;
        wait_all_results();
        cfg_write(CFG_CHIPSET_KIND, KIND_VGA);
        cfg_write(CFG_IGNORE_BLANKING, 3'd0);
        cfg_write(CFG_IGNORE_OE_256, 3'd1);
        cfg_write(CFG_IGNORE_EXT_MEM, 3'd0);
        sender_quiet   = 1;
        receiver_quiet = 1;
        start = accesses_sent;
        while (accesses_sent - start < BURST_ACCESSES)
            send_random_transaction();
        sender_quiet   = 0;
        receiver_quiet = 0;
    endtask

    initial begin
        model_cfg       = '{chipset_kind: KIND_VGA, ignore_blanking: 1'b0,
                            ignore_oddeven_256: 1'b1, ignore_ext_mem: 1'b0};
        seq_index       = '0;
        seq_reset       = '0;
        seq_clocking    = '0;
        seq_map_mask    = '0;
        seq_char_map    = '0;
        seq_mem_mode    = '0;
        blank_on        = 1'b0;
        chain4_on       = 1'b0;
        slow_map_mask   = 1'b0;
        slow_oddeven    = 1'b0;
        slow_small_mem  = 1'b0;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= CFG_CHIPSET_KIND;
        i_cfg_data      <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_accesses();
        test_config_phases();
        test_back_to_back();

        wait_all_results();
        if (expected_results.size() != 0) begin
            $display("%0t: %0d results expected but never returned", $time,
                     expected_results.size());
            mismatch_count += expected_results.size();
        end
        if (mismatch_count == 0)
            $display("** vga_sequencer_register_file: PASSED **");
        else
            $display("** vga_sequencer_register_file: FAILED **");
        $finish;
    end

endmodule
